// ===== hdl/cbf_pkg.sv =====
// Shared types, codes and sizing constants of the counting Bloom filter.
package cbf_pkg;

  // Store geometry.
  localparam int unsigned MAX_PARTITIONS = 16;
  localparam int unsigned MAX_SLOTS      = 4096;
  localparam int unsigned COUNTER_BITS   = 8;
  localparam int unsigned PART_W  = $clog2(MAX_PARTITIONS);
  localparam int unsigned SLOT_W  = $clog2(MAX_SLOTS);
  localparam int unsigned ADDR_W  = PART_W + SLOT_W;
  localparam int unsigned KCFG_W  = 5;
  localparam int unsigned MCFG_W  = 13;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

  // Hash constants.
  localparam logic [63:0] MIX_MUL   = 64'h2127599bf4325c37;
  localparam logic [63:0] HASH_MUL  = 64'h880355f21e6d1965;
  localparam logic [63:0] HASH_SEED = HASH_MUL << 3;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PARTITION_COUNT     = 2'd0;
  localparam logic [1:0] CFG_SLOTS_PER_PARTITION = 2'd1;
  localparam logic [1:0] CFG_HASH_SALT           = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
  } cbf_req_t;

  typedef struct packed {
    logic                hit;
    logic [COUNT_W-1:0]  element_count;
  } cbf_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_wr;
    logic hash_start;
    logic rem_start;
    logic iter_load;
    logic mem_upd;
    logic iter_next;
    logic finish;
  } cbf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic rem_done;
    logic iter_last;
    logic find_miss;
    logic out_free;
  } cbf_sts_t;

endpackage

// ===== hdl/cbf_hash.sv =====
// Salted fasthash mixer built on one shared 32x32 multiplier.
module cbf_hash import cbf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  input  logic [63:0] salt_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  logic        busy_q, done_q;
  logic [1:0]  stage_q, phase_q;
  logic [63:0] a_q, acc_q, z_q;
  logic [63:0] b_op;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] acc_mix;

  // Stage one multiplies by the hash constant, the others by the mix constant.
  assign b_op = (stage_q == 2'd1) ? HASH_MUL : MIX_MUL;

  // Low 64 bits of a 64x64 product from three partial products.
  always_comb begin
    case (phase_q)
      2'd0: begin
        mul_a = a_q[31:0];
        mul_b = b_op[31:0];
      end
      2'd1: begin
        mul_a = a_q[31:0];
        mul_b = b_op[63:32];
      end
      default: begin
        mul_a = a_q[63:32];
        mul_b = b_op[31:0];
      end
    endcase
  end

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign acc_mix = acc_q ^ (acc_q >> 47);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      stage_q <= 2'd0;
      phase_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        stage_q <= 2'd0;
        phase_q <= 2'd0;
      end else if (busy_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          stage_q <= stage_q + 2'd1;
          if (stage_q == 2'd2) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // Operand, accumulator and result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= key_i ^ (key_i >> 23);
    end else if (busy_q) begin
      case (phase_q)
        2'd0: acc_q <= prod;
        2'd1, 2'd2: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
        default: begin
          case (stage_q)
            2'd0:    a_q <= HASH_SEED ^ acc_mix;
            2'd1:    a_q <= acc_q ^ (acc_q >> 23);
            default: z_q <= acc_mix ^ salt_i;
          endcase
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign hash_o = z_q;

endmodule

// ===== hdl/cbf_rem.sv =====
// Two-lane restoring remainder unit, one dividend bit per cycle.
module cbf_rem import cbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       num_a_i,
  input  logic [31:0]       num_b_i,
  input  logic [SLOT_W:0]   modulus_i,
  output logic              done_o,
  output logic [SLOT_W-1:0] rem_a_o,
  output logic [SLOT_W-1:0] rem_b_o
);

  logic              busy_q, done_q;
  logic [4:0]        cnt_q;
  logic [31:0]       na_q, nb_q;
  logic [SLOT_W-1:0] ra_q, rb_q;
  logic [SLOT_W:0]   ta, tb;

  // Shift in the next bit and subtract the modulus when it fits.
  always_comb begin
    ta = {ra_q, na_q[31]};
    tb = {rb_q, nb_q[31]};
    if (ta >= modulus_i) ta = ta - modulus_i;
    if (tb >= modulus_i) tb = tb - modulus_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      na_q <= num_a_i;
      nb_q <= num_b_i;
      ra_q <= '0;
      rb_q <= '0;
    end else if (busy_q) begin
      na_q <= {na_q[30:0], 1'b0};
      nb_q <= {nb_q[30:0], 1'b0};
      ra_q <= ta[SLOT_W-1:0];
      rb_q <= tb[SLOT_W-1:0];
    end
  end

  assign done_o  = done_q;
  assign rem_a_o = ra_q;
  assign rem_b_o = rb_q;

endmodule

// ===== hdl/cbf_datapath.sv =====
// Datapath: configuration, hashing, slot walk, counter store and result register.
module cbf_datapath import cbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cbf_cmd_t   cmd_i,
  output cbf_sts_t   sts_o,
  input  cbf_req_t   req_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cbf_rsp_t   out_data_o
);

  logic [KCFG_W-1:0] cfg_k_q;
  logic [MCFG_W-1:0] cfg_m_q;
  logic [63:0]       cfg_salt_q;
  logic [KCFG_W-1:0] k_eff;
  logic [SLOT_W:0]   m_eff;

  logic [1:0]        req_q;
  logic              hash_done;
  logic [63:0]       hash_z;
  logic              rem_done;
  logic [SLOT_W-1:0] rem_h1, rem_h2;

  logic [SLOT_W-1:0] r_q, step_q;
  logic [ADDR_W-1:0] base_q;
  logic [KCFG_W-1:0] idx_q;
  logic [SLOT_W:0]   r_sum;
  logic [SLOT_W-1:0] r_next;
  logic [ADDR_W-1:0] addr;

  logic [COUNTER_BITS-1:0] mem_q [2**ADDR_W];
  logic [COUNTER_BITS-1:0] rdata_q;
  logic [COUNTER_BITS-1:0] upd_data;
  logic                    upd_we;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [COUNTER_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]       clr_q;

  logic               hit_q;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  cbf_rsp_t           out_q;
  logic               is_find;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q    <= KCFG_W'(1);
      cfg_m_q    <= MCFG_W'(MAX_SLOTS);
      cfg_salt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PARTITION_COUNT:     cfg_k_q    <= cfg_data_i[KCFG_W-1:0];
        CFG_SLOTS_PER_PARTITION: cfg_m_q    <= cfg_data_i[MCFG_W-1:0];
        CFG_HASH_SALT:           cfg_salt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the configured sizes into their legal ranges.
  always_comb begin
    if (cfg_k_q == '0) k_eff = KCFG_W'(1);
    else if (cfg_k_q > KCFG_W'(MAX_PARTITIONS)) k_eff = KCFG_W'(MAX_PARTITIONS);
    else k_eff = cfg_k_q;
    if (cfg_m_q == '0) m_eff = (SLOT_W+1)'(1);
    else if (cfg_m_q > MCFG_W'(MAX_SLOTS)) m_eff = (SLOT_W+1)'(MAX_SLOTS);
    else m_eff = cfg_m_q[SLOT_W:0];
  end

  // Request code held for the whole transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_start) req_q <= req_i.req_type;
  end

  assign is_find = req_q[1];

  cbf_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (req_i.key),
    .salt_i  (cfg_salt_q),
    .done_o  (hash_done),
    .hash_o  (hash_z)
  );

  cbf_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.rem_start),
    .num_a_i   (hash_z[31:0]),
    .num_b_i   (hash_z[63:32]),
    .modulus_i (m_eff),
    .done_o    (rem_done),
    .rem_a_o   (rem_h1),
    .rem_b_o   (rem_h2)
  );

  // Slot walk: each partition adds h2 mod m to the slot and m to the base.
  assign r_sum  = {1'b0, r_q} + {1'b0, step_q};
  assign r_next = (r_sum >= m_eff) ? SLOT_W'(r_sum - m_eff) : r_sum[SLOT_W-1:0];
  assign addr   = base_q + ADDR_W'(r_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_load) begin
      r_q    <= rem_h1;
      step_q <= rem_h2;
      base_q <= '0;
      idx_q  <= '0;
    end else if (cmd_i.iter_next) begin
      r_q    <= r_next;
      base_q <= base_q + ADDR_W'(m_eff);
      idx_q  <= idx_q + KCFG_W'(1);
    end
  end

  // Counter update: saturating increment or decrement of a nonzero counter.
  always_comb begin
    upd_data = rdata_q;
    upd_we   = 1'b0;
    if (req_q == REQ_INSERT) begin
      upd_we = 1'b1;
      if (rdata_q != COUNTER_MAX) upd_data = rdata_q + COUNTER_BITS'(1);
    end else if (req_q == REQ_REMOVE) begin
      upd_we = 1'b1;
      if (rdata_q != '0) upd_data = rdata_q - COUNTER_BITS'(1);
    end
  end

  // Store write port is shared by the clearing pass and counter updates.
  assign mem_we    = cmd_i.clr_wr | (cmd_i.mem_upd & upd_we);
  assign mem_addr  = cmd_i.clr_wr ? clr_q : addr;
  assign mem_wdata = cmd_i.clr_wr ? '0 : upd_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Hit flag, element count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.iter_load) begin
        hit_q <= is_find;
      end else if (cmd_i.mem_upd) begin
        if (req_q == REQ_REMOVE && rdata_q != '0) hit_q <= 1'b1;
        if (is_find && rdata_q == '0) hit_q <= 1'b0;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (req_q == REQ_INSERT && count_q != '1) count_q <= count_q + COUNT_W'(1);
        if (req_q == REQ_REMOVE && count_q != '0) count_q <= count_q - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.hit <= hit_q;
      if (req_q == REQ_INSERT && count_q != '1)
        out_q.element_count <= count_q + COUNT_W'(1);
      else if (req_q == REQ_REMOVE && count_q != '0)
        out_q.element_count <= count_q - COUNT_W'(1);
      else
        out_q.element_count <= count_q;
    end
  end

  // Status back to the controller.
  assign sts_o.clr_last  = (clr_q == '1);
  assign sts_o.hash_done = hash_done;
  assign sts_o.rem_done  = rem_done;
  assign sts_o.iter_last = (idx_q == k_eff - KCFG_W'(1));
  assign sts_o.find_miss = is_find && (rdata_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/cbf_ctrl.sv =====
// Controller state machine that sequences clearing, hashing, the remainder, the slot walk and the result.
module cbf_ctrl import cbf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cbf_sts_t sts_i,
  output cbf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_REM,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.hash_start = 1'b1;
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.rem_start = 1'b1;
          state_d = ST_REM;
        end
      end
      ST_REM: begin
        if (sts_i.rem_done) begin
          cmd_o.iter_load = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.mem_upd = 1'b1;
        if (sts_i.find_miss || sts_i.iter_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.iter_next = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/counting_bloom_filter.sv =====
// From acceptance to a valid result, a request for k partitions passes through hashing
// on one 32x32 multiplier, the remainder unit, a read and an update of the store per
// partition, and the registering of the result. A new request is taken only once the
// previous one has finished; a result waiting in the output register stalls the next
// transaction just before its own result.
// Reset restores the default configuration and clears the element count, then a
// clearing pass writes all 65536 counters to zero; no request is taken during that
// pass. Configuration writes are accepted in every cycle.
module counting_bloom_filter import cbf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cbf_req_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cbf_rsp_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cbf_cmd_t cmd;
  cbf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/counting_bloom_filter_test.sv =====
// Testbench for the counting Bloom filter: random driver, monitor and local predictor.
`timescale 1ns / 100ps
module counting_bloom_filter_test;
  import cbf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned STORE_SIZE  = MAX_PARTITIONS * MAX_SLOTS;
  localparam int unsigned LONG_HOLD   = 400;
  // Index beyond the register list; a write to it must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  cbf_req_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  cbf_rsp_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  counting_bloom_filter uut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow state of the filter.
  logic [COUNTER_BITS-1:0] shadow_counters [STORE_SIZE];
  logic [COUNT_W-1:0]      shadow_count;
  logic [KCFG_W-1:0]       shadow_parts;
  logic [MCFG_W-1:0]       shadow_slots;
  logic [63:0]             shadow_salt;

  cbf_req_t pending_reqs[$];
  cbf_rsp_t expected_rsps[$];
  logic [63:0] key_pool[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned reqs_sent = 0;
  int unsigned rsps_seen = 0;
  int unsigned cfg_writes = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit req_taken = 1'b0;
  bit cfg_taken = 1'b0;

  function automatic logic [63:0] mix64(logic [63:0] h);
    h = h ^ (h >> 23);
    h = h * MIX_MUL;
    h = h ^ (h >> 47);
    return h;
  endfunction

  // Computes the response to one request and updates the shadow state.
  function automatic cbf_rsp_t filter_lookup(cbf_req_t rq);
    cbf_rsp_t    rs;
    logic [63:0] z, h1, h2, m, j;
    int unsigned k;
    rs = '0;
    // The seed is XORed with the mixed key before the multiply.
    z = mix64(((64'd8 * HASH_MUL) ^ mix64(rq.key)) * HASH_MUL) ^ shadow_salt;
    h1 = {32'd0, z[31:0]};
    h2 = {32'd0, z[63:32]};
    k = (shadow_parts == 0) ? 1 : (shadow_parts > MAX_PARTITIONS) ? MAX_PARTITIONS
        : shadow_parts;
    m = (shadow_slots == 0) ? 1 : (shadow_slots > MAX_SLOTS) ? MAX_SLOTS : shadow_slots;
    if (rq.req_type == REQ_INSERT) begin
      for (int i = 0; i < k; i++) begin
        j = ((h1 + i * h2) % m) + i * m;
        if (j < STORE_SIZE && shadow_counters[j] != COUNTER_MAX)
          shadow_counters[j] = shadow_counters[j] + 1'b1;
      end
      if (shadow_count != '1) shadow_count = shadow_count + 1'b1;
    end else if (rq.req_type == REQ_REMOVE) begin
      for (int i = 0; i < k; i++) begin
        j = ((h1 + i * h2) % m) + i * m;
        if (j < STORE_SIZE && shadow_counters[j] != 0) begin
          shadow_counters[j] = shadow_counters[j] - 1'b1;
          rs.hit = 1'b1;
        end
      end
      if (shadow_count != 0) shadow_count = shadow_count - 1'b1;
    end else begin
      // Find, and the spare code, stop at the first empty counter.
      rs.hit = 1'b1;
      for (int i = 0; i < k; i++) begin
        j = ((h1 + i * h2) % m) + i * m;
        if (j >= STORE_SIZE || shadow_counters[j] == 0) begin
          rs.hit = 1'b0;
          break;
        end
      end
    end
    rs.element_count = shadow_count;
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Cycle count and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles,
               expected_rsps.size());
      $display("counting_bloom_filter verification failed");
      $finish;
    end
  end

  // Monitor: records accepted transactions and checks responses.
  always @(posedge clk_i) begin
    cbf_rsp_t want;
    req_taken <= in_valid_i && in_ready_o;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      cfg_writes++;
      case (cfg_index_i)
        CFG_PARTITION_COUNT:     shadow_parts = cfg_data_i[KCFG_W-1:0];
        CFG_SLOTS_PER_PARTITION: shadow_slots = cfg_data_i[MCFG_W-1:0];
        CFG_HASH_SALT:           shadow_salt = cfg_data_i;
        default: ;
      endcase
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      reqs_sent++;
      expected_rsps.push_back(filter_lookup(in_data_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsps_seen++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", out_data_o, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (out_data_o.hit !== want.hit)
          report_mismatch("hit", out_data_o.hit, want.hit);
        if (out_data_o.element_count !== want.element_count)
          report_mismatch("element_count", out_data_o.element_count, want.element_count);
      end
    end
  end

  // Request driver: takes items from the pending queue, with random gaps.
  always @(negedge clk_i) begin
    static bit offering = 1'b0;
    static int unsigned gap = 0;
    cbf_req_t next;
    if (req_taken) offering = 1'b0;
    if (!offering && rst_ni) begin
      if (gap > 0) begin
        gap--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 17) - 1;
      end else if (pending_reqs.size() > 0) begin
        next = pending_reqs.pop_front();
        offering = 1'b1;
        in_data_i <= next;
      end
    end
    in_valid_i <= offering;
  end

  // Response receiver: random stalls plus one long hold-off.
  always @(negedge clk_i) begin
    static int unsigned stall = 0;
    static bit hold_used = 1'b0;
    if (long_hold && !hold_used) begin
      stall = LONG_HOLD;
      hold_used = 1'b1;
    end
    if (stall > 0) begin
      stall--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 17) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [4:0] parts, logic [12:0] slots, logic [63:0] salt);
    write_reg(CFG_PARTITION_COUNT, {$urandom, $urandom} & ~64'h1f | parts);
    write_reg(CFG_SLOTS_PER_PARTITION, {$urandom, $urandom} & ~64'h1fff | slots);
    write_reg(CFG_HASH_SALT, salt);
  endtask

  // Waits until every queued request has been answered, then lets the block settle.
  // The check runs at the rising edge, where the driver's offer is already visible.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic push_req(logic [1:0] rt, logic [63:0] key);
    cbf_req_t rq;
    rq.req_type = rt;
    rq.key = key;
    if (rt == REQ_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
    pending_reqs.push_back(rq);
  endtask

  function automatic logic [63:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 9) < 7)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  // Mix of inserts, removes, finds and spare codes, mostly on keys already inserted.
  task automatic random_reqs(int unsigned count, int unsigned insert_weight);
    int unsigned r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 15);
      if (r < insert_weight)  push_req(REQ_INSERT, pick_key());
      else if (r < 10)        push_req(REQ_REMOVE, pick_key());
      else if (r < 15)        push_req(REQ_FIND, pick_key());
      else                    push_req(REQ_SPARE, pick_key());
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_SIZE; i++) shadow_counters[i] = '0;
    shadow_count = '0;
    shadow_parts = 5'd1;
    shadow_slots = 13'd4096;
    shadow_salt  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty filter, key extremes, every request code, reset settings.
    push_req(REQ_FIND, 64'd0);
    push_req(REQ_REMOVE, 64'd0);
    push_req(REQ_INSERT, 64'd0);
    push_req(REQ_INSERT, '1);
    push_req(REQ_FIND, 64'd0);
    push_req(REQ_FIND, '1);
    push_req(REQ_SPARE, '1);
    push_req(REQ_REMOVE, 64'd0);
    push_req(REQ_REMOVE, 64'd0);
    push_req(REQ_FIND, 64'd0);
    drain();
    write_reg(CFG_UNUSED, '1);
    configure(5'd16, 13'd4096, '1);
    push_req(REQ_INSERT, 64'h5555_5555_5555_5555);
    push_req(REQ_FIND, 64'h5555_5555_5555_5555);
    push_req(REQ_FIND, 64'haaaa_aaaa_aaaa_aaaa);
    push_req(REQ_REMOVE, 64'h5555_5555_5555_5555);
    push_req(REQ_REMOVE, '1);
    push_req(REQ_FIND, '1);
    drain();

    // One counter per partition: drive the counters into saturation and back.
    configure(5'd1, 13'd1, {$urandom, $urandom});
    for (int n = 0; n < 262; n++) push_req(REQ_INSERT, {$urandom, $urandom});
    push_req(REQ_FIND, {$urandom, $urandom});
    for (int n = 0; n < 8; n++) push_req(REQ_REMOVE, {$urandom, $urandom});
    push_req(REQ_FIND, {$urandom, $urandom});
    drain();

    // All partitions, tiny partitions, with a long receiver hold-off.
    configure(5'd16, 13'd2, {$urandom, $urandom});
    long_hold = 1'b1;
    random_reqs(80, 6);
    drain();

    // Out-of-range settings and assorted random ones.
    configure(5'd0, 13'd0, {$urandom, $urandom});
    random_reqs(60, 6);
    drain();
    configure(5'd31, 13'd8191, {$urandom, $urandom});
    random_reqs(80, 7);
    drain();
    configure(5'd17, 13'd5000, 64'd0);
    random_reqs(60, 5);
    drain();
    configure($urandom_range(1, 16), $urandom_range(1, 64), {$urandom, $urandom});
    random_reqs(100, 6);
    drain();

    // Last part with no idling on either side.
    quiet = 1'b1;
    configure($urandom_range(2, 8), $urandom_range(3, 300), {$urandom, $urandom});
    random_reqs(120, 6);
    drain();

    $display("covered %0d requests, %0d responses, %0d register writes, %0d cycles",
             reqs_sent, rsps_seen, cfg_writes, cycles);
    $display("settings included counter saturation, out-of-range sizes and a long stall");
    if (errors == 0) begin
      $display("counting_bloom_filter verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("counting_bloom_filter verification failed");
    end
    $finish;
  end

endmodule
